// ===== rtl/fbm_value_noise_height_core_assert.svh =====
// assertion macros shared by the height core and its divider
// depends on clk and arst_n being visible in the using module
`ifndef FBM_VALUE_NOISE_HEIGHT_CORE_ASSERT_SVH
`define FBM_VALUE_NOISE_HEIGHT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FBMVN_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbmvn assertion failed");
// implication after a fixed number of cycles
`define FBMVN_ASSERT_DELAY(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("fbmvn assertion failed");
`else
`define FBMVN_ASSERT_IMPLY(lbl, ante, cons)
`define FBMVN_ASSERT_DELAY(lbl, ante, dly, cons)
`endif
`endif

// ===== rtl/fbmvn_pkg.sv =====
// constants and helpers for the fbm value-noise height core
// no dependencies
`default_nettype none
package fbmvn_pkg;
	// configuration register indexes
	localparam logic [2:0] REG_NOISE_SEED     = 3'd0;
	localparam logic [2:0] REG_BASE_FREQUENCY = 3'd1;
	localparam logic [2:0] REG_OCTAVE_GAIN    = 3'd2;
	localparam logic [2:0] REG_OCTAVE_COUNT   = 3'd3;
	localparam logic [2:0] REG_MASK_MODE      = 3'd4;
	localparam logic [2:0] REG_EDGE_FALLOFF   = 3'd5;
	localparam logic [2:0] REG_RING_RADIUS    = 3'd6;
	localparam logic [2:0] REG_RING_WIDTH     = 3'd7;

	// reset values
	localparam logic [31:0] RST_NOISE_SEED     = 32'd0;
	localparam logic [23:0] RST_BASE_FREQUENCY = 24'd65536;
	localparam logic [15:0] RST_OCTAVE_GAIN    = 16'd32768;
	localparam logic [3:0]  RST_OCTAVE_COUNT   = 4'd4;
	localparam logic [1:0]  RST_MASK_MODE      = 2'd0;
	localparam logic [15:0] RST_EDGE_FALLOFF   = 16'd45875;
	localparam logic [16:0] RST_RING_RADIUS    = 17'd39322;
	localparam logic [16:0] RST_RING_WIDTH     = 17'd16384;

	// lattice hash
	localparam logic [31:0] HASH_KX   = 32'd374761393;
	localparam logic [31:0] HASH_KZ   = 32'd668265263;
	localparam logic [31:0] HASH_MIX  = 32'd1274126177;
	localparam logic [31:0] SEED_STEP = 32'd1013;

	// fixed point
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [17:0] SMOOTH_3X   = 18'd196608;
	localparam logic [16:0] WIDTH_FLOOR = 17'd66;
	localparam logic [14:0] FRAC_035    = 15'd22938;
	localparam logic [31:0] ROUND_HALF  = 32'd32768;

	// mask mode bits
	localparam int MASK_ISLAND_BIT = 0;
	localparam int MASK_RING_BIT   = 1;

	// floor((a*(1-t) + b*t)), t in q0.16 up to one
	function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
		input logic [16:0] t);
		logic [33:0] acc;
		acc = 34'(a) * 34'(ONE_Q16 - t) + 34'(b) * 34'(t);
		return acc[31:16];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fbmvn_div.sv =====
// pipelined restoring divider, one quotient bit per stage, sideband carried along
// uses fbm_value_noise_height_core_assert.svh
`default_nettype none
`include "fbm_value_noise_height_core_assert.svh"
module fbmvn_div #(
	parameter int NW = 34,
	parameter int DW = 17,
	parameter int QW = 16,
	parameter int SW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] out_quo,
	output logic [SW-1:0] out_side
);
	localparam int CW = NW + DW + QW;

	logic          vld_s  [QW];
	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar gi = 0; gi < QW; gi++) begin : g_st
		localparam int B = QW - 1 - gi;
		logic          vld_in;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [SW-1:0] side_in;
		logic [CW-1:0] trial;
		logic [CW-1:0] remx;
		logic          ge;
		logic [QW-1:0] quo_nx;

		if (gi == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = in_num;
			assign den_in  = in_den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[gi-1];
			assign rem_in  = rem_s[gi-1];
			assign den_in  = den_s[gi-1];
			assign quo_in  = quo_s[gi-1];
			assign side_in = side_s[gi-1];
		end

		assign trial = CW'(den_in) << B;
		assign remx  = CW'(rem_in);
		assign ge    = remx >= trial;

		always_comb begin
			quo_nx = quo_in;
			quo_nx[B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else begin
				vld_s[gi] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[gi]  <= ge ? NW'(remx - trial) : rem_in;
			den_s[gi]  <= den_in;
			quo_s[gi]  <= quo_nx;
			side_s[gi] <= side_in;
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_quo  = quo_s[QW-1];
	assign out_side = side_s[QW-1];

	`FBMVN_ASSERT_DELAY(a_div_latency, in_vld, QW, out_vld)
	`FBMVN_ASSERT_IMPLY(a_div_nonzero, in_vld, in_den != '0)
	`FBMVN_ASSERT_IMPLY(a_div_fits, in_vld, CW'(in_num) < (CW'(in_den) << QW))
endmodule
`default_nettype wire

// ===== rtl/fbm_value_noise_height_core.sv =====
// fractal value-noise terrain height core, fully pipelined, one point per clock
// depends on fbmvn_pkg, fbmvn_div and fbm_value_noise_height_core_assert.svh
//
// usage
//  - request channel: pulse start with pos_x/pos_z (signed q1.16). busy is always low,
//    so every cycle with start high is an accepted request; back-to-back requests are fine
//  - result channel: done is high for exactly one cycle with height (q0.16); results
//    come out in request order, one per request, and cannot be held off
//  - pipeline order from the accepting edge to done: noise front, octave accumulation,
//    normalize divider, shaping, square root, island falloff with its divider, and ring
//    plateau with its two dividers
//  - throughput: one point per cycle; every loop is unrolled into register stages
//    and every divide or root takes one bit per stage
//  - config: cfg_we/cfg_index/cfg_wdata write one register per cycle; the user must write
//    only while no request is in flight (not enforced here); new values apply to the next request
//  - reset: arst_n clears all valid bits and loads register defaults; nothing is in
//    flight after reset
`default_nettype none
`include "fbm_value_noise_height_core_assert.svh"
module fbm_value_noise_height_core #(
	parameter int OCTAVES_MAX     = 8,
	parameter int LACUNARITY_LOG2 = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	// request
	input  logic               start,
	output logic               busy,
	input  logic signed [17:0] pos_x,
	input  logic signed [17:0] pos_z,
	// result
	output logic               done,
	output logic        [15:0] height,
	// configuration
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_wdata
);
	localparam int OM       = OCTAVES_MAX;
	localparam int CNTW     = $clog2(OM + 1) + 1;
	localparam int SUMW     = 33 + $clog2(OM);
	localparam int NRMW     = 18 + $clog2(OM);
	localparam int SQ_STEPS = 18;
	localparam int LAT      = 83 + OM;

	// ---------------------------------------------------------------- config
	logic [31:0] noise_seed_q;
	logic [23:0] base_frequency_q;
	logic [15:0] octave_gain_q;
	logic [3:0]  octave_count_q;
	logic [1:0]  mask_mode_q;
	logic [15:0] edge_falloff_q;
	logic [16:0] ring_radius_q;
	logic [16:0] ring_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q     <= fbmvn_pkg::RST_NOISE_SEED;
			base_frequency_q <= fbmvn_pkg::RST_BASE_FREQUENCY;
			octave_gain_q    <= fbmvn_pkg::RST_OCTAVE_GAIN;
			octave_count_q   <= fbmvn_pkg::RST_OCTAVE_COUNT;
			mask_mode_q      <= fbmvn_pkg::RST_MASK_MODE;
			edge_falloff_q   <= fbmvn_pkg::RST_EDGE_FALLOFF;
			ring_radius_q    <= fbmvn_pkg::RST_RING_RADIUS;
			ring_width_q     <= fbmvn_pkg::RST_RING_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				fbmvn_pkg::REG_NOISE_SEED:     noise_seed_q     <= cfg_wdata;
				fbmvn_pkg::REG_BASE_FREQUENCY: base_frequency_q <= cfg_wdata[23:0];
				fbmvn_pkg::REG_OCTAVE_GAIN:    octave_gain_q    <= cfg_wdata[15:0];
				fbmvn_pkg::REG_OCTAVE_COUNT:   octave_count_q   <= cfg_wdata[3:0];
				fbmvn_pkg::REG_MASK_MODE:      mask_mode_q      <= cfg_wdata[1:0];
				fbmvn_pkg::REG_EDGE_FALLOFF:   edge_falloff_q   <= cfg_wdata[15:0];
				fbmvn_pkg::REG_RING_RADIUS:    ring_radius_q    <= cfg_wdata[16:0];
				fbmvn_pkg::REG_RING_WIDTH:     ring_width_q     <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// pipeline never stalls
	assign busy = 1'b0;

	// effective octave count: zero acts as one, clamp to the lane count
	logic [CNTW-1:0] cnt_eff;
	always_comb begin
		cnt_eff = CNTW'(octave_count_q);
		if (cnt_eff == '0) begin
			cnt_eff = CNTW'(1);
		end else if (cnt_eff > CNTW'(OM)) begin
			cnt_eff = CNTW'(OM);
		end
	end

	// ---------------------------------------------------------------- valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_a [OM];
	logic vld_m1, vld_m2;
	logic sq_vld_s [SQ_STEPS];
	logic vld_i1, vld_i2, vld_i3, vld_g1, vld_g2, vld_g3, vld_g4, vld_g5, vld_g6;
	logic dn_vld, di_vld, dri_vld, dro_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			vld_i1 <= 1'b0;
			vld_i2 <= 1'b0;
			vld_i3 <= 1'b0;
			vld_g1 <= 1'b0;
			vld_g2 <= 1'b0;
			vld_g3 <= 1'b0;
			vld_g4 <= 1'b0;
			vld_g5 <= 1'b0;
			vld_g6 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_m1 <= dn_vld;
			vld_m2 <= vld_m1;
			vld_i1 <= sq_vld_s[SQ_STEPS-1];
			vld_i2 <= di_vld;
			vld_i3 <= vld_i2;
			vld_g1 <= vld_i3;
			vld_g2 <= vld_g1;
			vld_g3 <= dri_vld & dro_vld;
			vld_g4 <= vld_g3;
			vld_g5 <= vld_g4;
			vld_g6 <= vld_g5;
		end
	end

	// ---------------------------------------------------------------- s1: scale coordinates
	logic signed [42:0] ux_s1, uz_s1;
	logic        [35:0] nsq_s1;
	logic signed [35:0] xsq_c, zsq_c;
	logic signed [24:0] freq_c;

	assign freq_c = $signed({1'b0, base_frequency_q});
	assign xsq_c  = pos_x * pos_x;
	assign zsq_c  = pos_z * pos_z;

	always_ff @(posedge clk) begin
		ux_s1  <= pos_x * freq_c;
		uz_s1  <= pos_z * freq_c;
		nsq_s1 <= $unsigned(xsq_c) + $unsigned(zsq_c);
	end

	// ---------------------------------------------------------------- s2..s6: octave lanes
	logic [31:0] mx_s2 [OM];
	logic [31:0] mz_s2 [OM];
	logic [15:0] tx_s2 [OM];
	logic [15:0] tz_s2 [OM];
	logic [31:0] hm_s3 [OM][4];
	logic [31:0] tsqx_s3 [OM];
	logic [31:0] tsqz_s3 [OM];
	logic [17:0] tlinx_s3 [OM];
	logic [17:0] tlinz_s3 [OM];
	logic [15:0] val_s4 [OM][4];
	logic [16:0] fx_s4 [OM];
	logic [16:0] fz_s4 [OM];
	logic [15:0] ab_s5 [OM];
	logic [15:0] cd_s5 [OM];
	logic [16:0] fz_s5 [OM];
	logic [15:0] n_s6 [OM];
	logic [35:0] nsq_s2, nsq_s3, nsq_s4, nsq_s5, nsq_s6;

	always_ff @(posedge clk) begin
		nsq_s2 <= nsq_s1;
		nsq_s3 <= nsq_s2;
		nsq_s4 <= nsq_s3;
		nsq_s5 <= nsq_s4;
		nsq_s6 <= nsq_s5;
	end

	for (genvar o = 0; o < OM; o++) begin : g_oct
		localparam int SH = o * LACUNARITY_LOG2;
		localparam logic [31:0] SEED_OFS = 32'(o) * fbmvn_pkg::SEED_STEP;
		logic [63:0] ux64, uz64;
		logic [31:0] seed;
		logic [31:0] hx [2];
		logic [31:0] hz [2];
		logic [31:0] hc [4];
		logic [31:0] gc [4];
		logic [31:0] hs [4];
		logic [49:0] smx, smz;

		// floor of the lattice coordinate keeps the low 32 integer bits
		assign ux64 = {{21{ux_s1[42]}}, ux_s1} << SH;
		assign uz64 = {{21{uz_s1[42]}}, uz_s1} << SH;
		assign seed = noise_seed_q + SEED_OFS;

		// neighbor cell products are the base product plus the constant
		assign hx[0] = mx_s2[o];
		assign hx[1] = mx_s2[o] + fbmvn_pkg::HASH_KX;
		assign hz[0] = mz_s2[o];
		assign hz[1] = mz_s2[o] + fbmvn_pkg::HASH_KZ;

		for (genvar c = 0; c < 4; c++) begin : g_corner
			assign hc[c] = seed ^ hx[c % 2] ^ hz[c / 2];
			assign gc[c] = hc[c] ^ (hc[c] >> 13);
			assign hs[c] = hm_s3[o][c] ^ (hm_s3[o][c] >> 16);
		end

		assign smx = 50'(tsqx_s3[o]) * 50'(tlinx_s3[o]);
		assign smz = 50'(tsqz_s3[o]) * 50'(tlinz_s3[o]);

		always_ff @(posedge clk) begin
			// s2: cell products and fractions
			mx_s2[o] <= ux64[63:32] * fbmvn_pkg::HASH_KX;
			mz_s2[o] <= uz64[63:32] * fbmvn_pkg::HASH_KZ;
			tx_s2[o] <= ux64[31:16];
			tz_s2[o] <= uz64[31:16];
			// s3: final hash multiply, smoothstep first half
			for (int c = 0; c < 4; c++) begin
				hm_s3[o][c] <= gc[c] * fbmvn_pkg::HASH_MIX;
			end
			tsqx_s3[o]  <= 32'(tx_s2[o]) * 32'(tx_s2[o]);
			tsqz_s3[o]  <= 32'(tz_s2[o]) * 32'(tz_s2[o]);
			tlinx_s3[o] <= fbmvn_pkg::SMOOTH_3X - {1'b0, tx_s2[o], 1'b0};
			tlinz_s3[o] <= fbmvn_pkg::SMOOTH_3X - {1'b0, tz_s2[o], 1'b0};
			// s4: corner values and smoothed weights
			for (int c = 0; c < 4; c++) begin
				val_s4[o][c] <= hs[c][23:8];
			end
			fx_s4[o] <= smx[48:32];
			fz_s4[o] <= smz[48:32];
			// s5: blend along x
			ab_s5[o] <= fbmvn_pkg::lerp16(val_s4[o][0], val_s4[o][1], fx_s4[o]);
			cd_s5[o] <= fbmvn_pkg::lerp16(val_s4[o][2], val_s4[o][3], fx_s4[o]);
			fz_s5[o] <= fz_s4[o];
			// s6: blend along z
			n_s6[o] <= fbmvn_pkg::lerp16(ab_s5[o], cd_s5[o], fz_s5[o]);
		end
	end

	// ---------------------------------------------------------------- octave accumulation
	logic [SUMW-1:0] sum_a [OM];
	logic [NRMW-1:0] nrm_a [OM];
	logic [16:0]     amp_a [OM];
	logic [15:0]     noi_a [OM][OM];
	logic [35:0]     nsq_a [OM];

	for (genvar k = 0; k < OM; k++) begin : g_acc
		logic            vld_in;
		logic [SUMW-1:0] sum_in;
		logic [NRMW-1:0] nrm_in;
		logic [16:0]     amp_in;
		logic [15:0]     noise_k;
		logic [35:0]     nsq_in;
		logic            en;
		logic [32:0]     wprod;
		logic [32:0]     gprod;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s6;
			assign sum_in  = '0;
			assign nrm_in  = '0;
			assign amp_in  = fbmvn_pkg::ONE_Q16;
			assign noise_k = n_s6[0];
			assign nsq_in  = nsq_s6;
		end else begin : g_next
			assign vld_in  = vld_a[k-1];
			assign sum_in  = sum_a[k-1];
			assign nrm_in  = nrm_a[k-1];
			assign amp_in  = amp_a[k-1];
			assign noise_k = noi_a[k-1][k];
			assign nsq_in  = nsq_a[k-1];
		end

		assign en    = CNTW'(k) < cnt_eff;
		assign wprod = 33'(amp_in) * 33'(noise_k);
		assign gprod = 33'(amp_in) * 33'(octave_gain_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[k] <= 1'b0;
			end else begin
				vld_a[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sum_a[k] <= sum_in + (en ? SUMW'(wprod) : '0);
			nrm_a[k] <= nrm_in + (en ? NRMW'(amp_in) : '0);
			amp_a[k] <= gprod[32:16];
			nsq_a[k] <= nsq_in;
			if (k == 0) begin
				noi_a[k] <= n_s6;
			end else begin
				noi_a[k] <= noi_a[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- normalize
	logic [15:0] dn_quo;
	logic [35:0] dn_nsq;

	fbmvn_div #(
		.NW (SUMW),
		.DW (NRMW),
		.QW (16),
		.SW (36)
	) u_div_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_a[OM-1]),
		.in_num   (sum_a[OM-1]),
		.in_den   (nrm_a[OM-1]),
		.in_side  (nsq_a[OM-1]),
		.out_vld  (dn_vld),
		.out_quo  (dn_quo),
		.out_side (dn_nsq)
	);

	// smoothstep shaping of the normalized sum
	logic [31:0] vsq_m1;
	logic [17:0] vlin_m1;
	logic [35:0] nsq_m1, nsq_m2;
	logic [15:0] vs_m2;
	logic [49:0] vsm_c;

	assign vsm_c = 50'(vsq_m1) * 50'(vlin_m1);

	always_ff @(posedge clk) begin
		vsq_m1  <= 32'(dn_quo) * 32'(dn_quo);
		vlin_m1 <= fbmvn_pkg::SMOOTH_3X - {1'b0, dn_quo, 1'b0};
		nsq_m1  <= dn_nsq;
		vs_m2   <= vsm_c[47:32];
		nsq_m2  <= nsq_m1;
	end

	// ---------------------------------------------------------------- radius, bit-pair sqrt
	logic [36:0] sq_rem_s  [SQ_STEPS];
	logic [36:0] sq_root_s [SQ_STEPS];
	logic [15:0] sq_v_s    [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [36:0] BIT = 37'(1) << (2 * (SQ_STEPS - 1 - j));
		logic        vld_in;
		logic [36:0] rem_in, root_in, trial;
		logic [15:0] v_in;
		logic        ge;

		if (j == 0) begin : g_first
			assign vld_in  = vld_m2;
			assign rem_in  = 37'(nsq_m2);
			assign root_in = '0;
			assign v_in    = vs_m2;
		end else begin : g_next
			assign vld_in  = sq_vld_s[j-1];
			assign rem_in  = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign v_in    = sq_v_s[j-1];
		end

		assign trial = root_in + BIT;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else begin
				sq_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[j]  <= ge ? rem_in - trial : rem_in;
			sq_root_s[j] <= ge ? (root_in >> 1) + BIT : root_in >> 1;
			sq_v_s[j]    <= v_in;
		end
	end

	// ---------------------------------------------------------------- island falloff
	logic [17:0] r_c, ef_c, dif_c;
	logic [16:0] den_raw_c, den_c;
	logic        gt_c, full_c;

	assign r_c       = sq_root_s[SQ_STEPS-1][17:0];
	assign ef_c      = 18'(edge_falloff_q);
	assign gt_c      = r_c > ef_c;
	assign dif_c     = r_c - ef_c;
	assign den_raw_c = fbmvn_pkg::ONE_Q16 - 17'(edge_falloff_q);
	assign den_c     = (den_raw_c < fbmvn_pkg::WIDTH_FLOOR) ? fbmvn_pkg::WIDTH_FLOOR : den_raw_c;
	assign full_c    = dif_c >= 18'(den_c);

	logic [33:0] isl_num_i1;
	logic [16:0] isl_den_i1;
	logic        isl_sat_i1;
	logic [17:0] r_i1;
	logic [15:0] v_i1;

	always_ff @(posedge clk) begin
		isl_num_i1 <= (gt_c && !full_c) ? {dif_c, 16'd0} : '0;
		isl_den_i1 <= den_c;
		isl_sat_i1 <= gt_c && full_c;
		r_i1       <= r_c;
		v_i1       <= sq_v_s[SQ_STEPS-1];
	end

	logic [15:0] di_quo;
	logic [34:0] di_side;

	fbmvn_div #(
		.NW (34),
		.DW (17),
		.QW (16),
		.SW (35)
	) u_div_island (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_i1),
		.in_num   (isl_num_i1),
		.in_den   (isl_den_i1),
		.in_side  ({isl_sat_i1, r_i1, v_i1}),
		.out_vld  (di_vld),
		.out_quo  (di_quo),
		.out_side (di_side)
	);

	logic [16:0] fall_c, fall_i2;
	logic [32:0] vf_i2;
	logic [15:0] v_i2, v_i3;
	logic [17:0] r_i2, r_i3;
	logic [49:0] vff_c;

	// saturated falloff drives the height to zero
	assign fall_c = di_side[34] ? 17'd0 : fbmvn_pkg::ONE_Q16 - 17'(di_quo);
	assign vff_c  = 50'(vf_i2) * 50'(fall_i2);

	always_ff @(posedge clk) begin
		fall_i2 <= fall_c;
		vf_i2   <= 33'(di_side[15:0]) * 33'(fall_c);
		v_i2    <= di_side[15:0];
		r_i2    <= di_side[33:16];
		v_i3    <= mask_mode_q[fbmvn_pkg::MASK_ISLAND_BIT] ? vff_c[47:32] : v_i2;
		r_i3    <= r_i2;
	end

	// ---------------------------------------------------------------- ring plateau
	logic [16:0] w_c;
	logic [31:0] w35p_c;
	logic [16:0] w_g1, w35_g1;
	logic [15:0] v_g1, v_g2;
	logic [17:0] r_g1;

	assign w_c    = (ring_width_q < fbmvn_pkg::WIDTH_FLOOR) ? fbmvn_pkg::WIDTH_FLOOR : ring_width_q;
	assign w35p_c = 32'(w_c) * 32'(fbmvn_pkg::FRAC_035) + fbmvn_pkg::ROUND_HALF;

	always_ff @(posedge clk) begin
		w_g1   <= w_c;
		w35_g1 <= 17'(w35p_c[31:16]);
		v_g1   <= v_i3;
		r_g1   <= r_i3;
	end

	logic signed [19:0] rr_c, ri_c, w20_c, w35_20_c;
	logic signed [19:0] e0i_c, e1i_c, e0o_c, e1o_c, difi_c, difo_c;
	logic               loi_c, hii_c, loo_c, hio_c;

	assign rr_c     = $signed(20'(ring_radius_q));
	assign ri_c     = $signed(20'(r_g1));
	assign w20_c    = $signed(20'(w_g1));
	assign w35_20_c = $signed(20'(w35_g1));
	assign e0i_c    = rr_c - w20_c;
	assign e1i_c    = rr_c - w35_20_c;
	assign e0o_c    = rr_c + w35_20_c;
	assign e1o_c    = rr_c + w20_c;
	assign loi_c    = ri_c <= e0i_c;
	assign hii_c    = ri_c >= e1i_c;
	assign loo_c    = ri_c <= e0o_c;
	assign hio_c    = ri_c >= e1o_c;
	assign difi_c   = ri_c - e0i_c;
	assign difo_c   = ri_c - e0o_c;

	logic [32:0] rin_num_g2, rout_num_g2;
	logic [16:0] rden_g2;
	logic        loi_g2, hii_g2, loo_g2, hio_g2;

	always_ff @(posedge clk) begin
		rin_num_g2  <= (!loi_c && !hii_c) ? {difi_c[16:0], 16'd0} : '0;
		rout_num_g2 <= (!loo_c && !hio_c) ? {difo_c[16:0], 16'd0} : '0;
		rden_g2     <= w_g1 - w35_g1;
		loi_g2      <= loi_c;
		hii_g2      <= hii_c;
		loo_g2      <= loo_c;
		hio_g2      <= hio_c;
		v_g2        <= v_g1;
	end

	logic [15:0] dri_quo, dro_quo;
	logic [17:0] dri_side;
	logic [1:0]  dro_side;

	fbmvn_div #(
		.NW (33),
		.DW (17),
		.QW (16),
		.SW (18)
	) u_div_ring_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_g2),
		.in_num   (rin_num_g2),
		.in_den   (rden_g2),
		.in_side  ({loi_g2, hii_g2, v_g2}),
		.out_vld  (dri_vld),
		.out_quo  (dri_quo),
		.out_side (dri_side)
	);

	fbmvn_div #(
		.NW (33),
		.DW (17),
		.QW (16),
		.SW (2)
	) u_div_ring_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_g2),
		.in_num   (rout_num_g2),
		.in_den   (rden_g2),
		.in_side  ({loo_g2, hio_g2}),
		.out_vld  (dro_vld),
		.out_quo  (dro_quo),
		.out_side (dro_side)
	);

	// edge smoothsteps, then plateau weight
	logic [31:0] isq_g3, osq_g3;
	logic [17:0] ilin_g3, olin_g3;
	logic        loi_g3, hii_g3, loo_g3, hio_g3;
	logic [15:0] v_g3, v_g4, v_g5;
	logic [49:0] ism_c, osm_c;
	logic [16:0] istep_c, ostep_c;
	logic [16:0] inner_g4, outer_g4, m_g5;
	logic [33:0] mprod_c, vprod_c;
	logic [15:0] height_g6;

	assign ism_c   = 50'(isq_g3) * 50'(ilin_g3);
	assign osm_c   = 50'(osq_g3) * 50'(olin_g3);
	assign istep_c = loi_g3 ? 17'd0 : (hii_g3 ? fbmvn_pkg::ONE_Q16 : ism_c[48:32]);
	assign ostep_c = loo_g3 ? 17'd0 : (hio_g3 ? fbmvn_pkg::ONE_Q16 : osm_c[48:32]);
	assign mprod_c = 34'(inner_g4) * 34'(outer_g4);
	assign vprod_c = 34'(v_g5) * 34'(m_g5);

	always_ff @(posedge clk) begin
		isq_g3    <= 32'(dri_quo) * 32'(dri_quo);
		osq_g3    <= 32'(dro_quo) * 32'(dro_quo);
		ilin_g3   <= fbmvn_pkg::SMOOTH_3X - {1'b0, dri_quo, 1'b0};
		olin_g3   <= fbmvn_pkg::SMOOTH_3X - {1'b0, dro_quo, 1'b0};
		loi_g3    <= dri_side[17];
		hii_g3    <= dri_side[16];
		loo_g3    <= dro_side[1];
		hio_g3    <= dro_side[0];
		v_g3      <= dri_side[15:0];
		inner_g4  <= istep_c;
		outer_g4  <= fbmvn_pkg::ONE_Q16 - ostep_c;
		v_g4      <= v_g3;
		m_g5      <= mprod_c[32:16];
		v_g5      <= v_g4;
		height_g6 <= mask_mode_q[fbmvn_pkg::MASK_RING_BIT] ? vprod_c[31:16] : v_g5;
	end

	assign done   = vld_g6;
	assign height = height_g6;

	`FBMVN_ASSERT_DELAY(a_req_gives_result, start, LAT, done)
	`FBMVN_ASSERT_DELAY(a_no_req_no_result, !start, LAT, !done)
	`FBMVN_ASSERT_IMPLY(a_root_range, vld_i1, r_i1 <= 18'd185363)
endmodule
`default_nettype wire
